// ===== rtl/core/ipc_pkg.sv =====
// shared types, codes and constants of the interrupt priority controller
`default_nettype none

package ipc_pkg;

    localparam int MAX_SOURCES_DEF    = 63;
    localparam int SOFTWARE_COUNT_DEF = 64;
    localparam int REGISTER_BYTES_DEF = 8;

    localparam int REG_BITS  = 64;
    localparam int SRC_NUM_W = 6;
    localparam int BYTE_W    = 8;
    localparam int LANE_W    = 3;
    localparam int CFG_W     = 6;

    localparam logic [SRC_NUM_W-1:0] SRC_CNT_RST = 6'd21;
    localparam logic [BYTE_W-1:0]    BYTE_ONES   = 8'hFF;

    typedef enum logic [0:0] {
        CFG_SOURCES_IN_USE  = 1'b0,
        CFG_NMI_BIT_WRITABLE = 1'b1
    } t_cfg_index;

    typedef enum logic [3:0] {
        ACT_WR_MASK = 4'd0,
        ACT_WR_PEND = 4'd1,
        ACT_RD_MASK = 4'd2,
        ACT_RD_PEND = 4'd3,
        ACT_RAISE   = 4'd4,
        ACT_NMI     = 4'd5,
        ACT_BRK     = 4'd6,
        ACT_EMU     = 4'd7,
        ACT_SWI     = 4'd8,
        ACT_RESET   = 4'd9,
        ACT_ACCEPT  = 4'd10
    } t_action;

    typedef enum logic [2:0] {
        KIND_RESET    = 3'd0,
        KIND_SOFTWARE = 3'd1,
        KIND_EMULATOR = 3'd2,
        KIND_BREAK    = 3'd3,
        KIND_NMI      = 3'd4,
        KIND_MASKABLE = 3'd5
    } t_kind;

    localparam logic [1:0] LVL_RESET = 2'd0;
    localparam logic [1:0] LVL_ONE   = 2'd1;
    localparam logic [1:0] LVL_TWO   = 2'd2;
    localparam logic [1:0] LVL_EMU   = 2'd3;

    typedef struct packed {
        logic [3:0]           action;
        logic [LANE_W-1:0]    byte_offset;
        logic [BYTE_W-1:0]    write_byte;
        logic [SRC_NUM_W-1:0] source_number;
        logic [SRC_NUM_W-1:0] software_number;
        logic                 master_enable;
        logic [1:0]           current_level;
        logic                 maskable_blocked;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0]    read_byte;
        logic                 taken;
        t_kind                taken_kind;
        logic [SRC_NUM_W-1:0] taken_number;
        logic [1:0]           new_level;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/interrupt_priority_controller_unit.sv =====
// top level of the interrupt priority controller: input register, update logic, result register
// an accepted input beat passes the input register, then the result register, to its result beat
// throughput: one beat per cycle; the flag update of a beat sits between the two registers
// a full pipeline stalls only while the output side holds back tready
// reset (synchronous, active low): pipeline empty, mask/pending/software/break/emulator clear,
// reset interrupt pending, 21 maskable sources, nmi bit not writable
`default_nettype none

module interrupt_priority_controller_unit
    import ipc_pkg::*;
#(
    parameter int MAX_SOURCES    = MAX_SOURCES_DEF,
    parameter int SOFTWARE_COUNT = SOFTWARE_COUNT_DEF,
    parameter int REGISTER_BYTES = REGISTER_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration write port
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_addr,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    // input stream
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    // byte_offset[2:0], write_byte[10:3], source_number[16:11], software_number[22:17],
    // master_enable[23], current_level[25:24], maskable_blocked[26], zero fill[31:27]
    input  wire logic [31:0]       i_s_tdata,
    // action[3:0]
    input  wire logic [3:0]        i_s_tuser,
    // result stream
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // read_byte[7:0], taken_number[13:8], new_level[15:14]
    output logic [15:0]            o_m_tdata,
    // taken[0], taken_kind[3:1]
    output logic [3:0]             o_m_tuser
);

    logic                 src_cnt_we;
    logic [SRC_NUM_W-1:0] r_src_cnt;
    logic                 r_nmi_wr;

    logic    r_in_vld;
    t_item   r_in;
    logic    r_out_vld;
    t_result r_out;
    t_result res;
    logic    adv;
    t_item   in_item;

    assign src_cnt_we = i_cfg_we && (i_cfg_addr == CFG_SOURCES_IN_USE);

    // configuration registers; the user must write them only while the pipeline is idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_cnt <= SRC_CNT_RST;
            r_nmi_wr  <= 1'b0;
        end else begin
            if (src_cnt_we) begin
                r_src_cnt <= i_cfg_wdata;
            end
            if (i_cfg_we && (i_cfg_addr == CFG_NMI_BIT_WRITABLE)) begin
                r_nmi_wr <= i_cfg_wdata[0];
            end
        end
    end

    // unpack the input beat
    assign in_item.action           = i_s_tuser;
    assign in_item.byte_offset      = i_s_tdata[2:0];
    assign in_item.write_byte       = i_s_tdata[10:3];
    assign in_item.source_number    = i_s_tdata[16:11];
    assign in_item.software_number  = i_s_tdata[22:17];
    assign in_item.master_enable    = i_s_tdata[23];
    assign in_item.current_level    = i_s_tdata[25:24];
    assign in_item.maskable_blocked = i_s_tdata[26];

    // a beat moves to the result register when that register is free or drains now
    assign adv        = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in <= in_item;
        end
    end

    // flag state is committed in the same cycle the beat enters the result register
    ipc_state #(
        .MAX_SOURCES    (MAX_SOURCES),
        .SOFTWARE_COUNT (SOFTWARE_COUNT),
        .REGISTER_BYTES (REGISTER_BYTES)
    ) u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_item    (r_in),
        .i_src_cnt (r_src_cnt),
        .i_nmi_wr  (r_nmi_wr),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out.new_level, r_out.taken_number, r_out.read_byte};
    assign o_m_tuser  = {r_out.taken_kind, r_out.taken};

    // nothing taken means an all-zero interrupt report
    a_idle_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.taken) |->
        (r_out.taken_kind == KIND_RESET && r_out.taken_number == '0 && r_out.new_level == '0))
        else $error("report fields set without a taken interrupt");

    // a maskable interrupt always enters level 1 with a nonzero source
    a_maskable_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.taken && r_out.taken_kind == KIND_MASKABLE) |->
        (r_out.new_level == LVL_ONE && r_out.taken_number != '0))
        else $error("maskable interrupt with bad level or source");

    // a read byte and a taken interrupt never share a beat
    a_read_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.read_byte != '0) |-> !r_out.taken)
        else $error("read data on an accept beat");

    // input side stalls only with both registers holding beats
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_vld && r_out_vld && !i_m_tready))
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== rtl/core/ipc_lsb_find.sv =====
// lowest-set-bit priority encoder
`default_nettype none

module ipc_lsb_find
    import ipc_pkg::*;
#(
    parameter int W  = 64,
    parameter int IW = (W > 1) ? $clog2(W) : 1
) (
    input  wire logic [W-1:0]  i_vec,
    output logic               o_found,
    output logic [IW-1:0]      o_idx
);

    always_comb begin
        o_idx = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                o_idx = IW'(i);
            end
        end
    end

    assign o_found = |i_vec;

endmodule

`default_nettype wire

// ===== rtl/core/ipc_state.sv =====
// flag state and per-beat update: register access, requests and priority accept
`default_nettype none

module ipc_state
    import ipc_pkg::*;
#(
    parameter int MAX_SOURCES    = MAX_SOURCES_DEF,
    parameter int SOFTWARE_COUNT = SOFTWARE_COUNT_DEF,
    parameter int REGISTER_BYTES = REGISTER_BYTES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire t_item                i_item,
    input  wire logic [SRC_NUM_W-1:0] i_src_cnt,
    input  wire logic                 i_nmi_wr,
    output t_result                   o_res
);

    localparam int SRC_W  = MAX_SOURCES + 1;
    localparam int SRC_IW = $clog2(SRC_W);
    localparam int SW_IW  = (SOFTWARE_COUNT > 1) ? $clog2(SOFTWARE_COUNT) : 1;

    logic [SRC_W-1:0]          r_mask, n_mask;
    logic [SRC_W-1:0]          r_pend, n_pend;
    logic [SOFTWARE_COUNT-1:0] r_sw,   n_sw;
    logic                      r_rst_flag, n_rst_flag;
    logic                      r_brk_flag, n_brk_flag;
    logic                      r_emu_flag, n_emu_flag;

    logic [SRC_NUM_W-1:0] src_n;
    logic [REG_BITS-1:0]  writable;
    logic [REG_BITS-1:0]  mask_wide, pend_wide, reg_wide, lane_wr;
    logic [SRC_W-1:0]     active, cand;
    logic                 lane_ok;
    logic                 sw_found, mk_found;
    logic [SW_IW-1:0]     sw_idx;
    logic [SRC_IW-1:0]    mk_idx;
    t_result              res;

    // effective source count, capped at the build limit
    assign src_n = (i_src_cnt > SRC_NUM_W'(MAX_SOURCES)) ? SRC_NUM_W'(MAX_SOURCES) : i_src_cnt;

    always_comb begin
        for (int i = 0; i < REG_BITS; i++) begin
            writable[i] = (7'(i) <= {1'b0, src_n});
        end
        writable[0] = writable[0] & i_nmi_wr;
    end

    assign mask_wide = REG_BITS'(r_mask);
    assign pend_wide = REG_BITS'(r_pend);
    assign lane_ok   = ({1'b0, i_item.byte_offset} < 4'(REGISTER_BYTES));
    assign reg_wide  = (i_item.action == ACT_WR_MASK) ? mask_wide : pend_wide;

    // byte lane replace, then cut to the writable bits
    always_comb begin
        lane_wr = reg_wide;
        for (int b = 0; b < REG_BITS / BYTE_W; b++) begin
            if (LANE_W'(b) == i_item.byte_offset) begin
                lane_wr[b*BYTE_W +: BYTE_W] = i_item.write_byte;
            end
        end
        lane_wr = lane_wr & writable;
    end

    assign active = r_pend & r_mask;

    always_comb begin
        cand = '0;
        for (int i = 1; i < SRC_W; i++) begin
            cand[i] = active[i] && (7'(i) <= {1'b0, src_n});
        end
    end

    ipc_lsb_find #(.W(SOFTWARE_COUNT), .IW(SW_IW)) u_sw_find (
        .i_vec   (r_sw),
        .o_found (sw_found),
        .o_idx   (sw_idx)
    );

    ipc_lsb_find #(.W(SRC_W), .IW(SRC_IW)) u_mk_find (
        .i_vec   (cand),
        .o_found (mk_found),
        .o_idx   (mk_idx)
    );

    always_comb begin
        n_mask     = r_mask;
        n_pend     = r_pend;
        n_sw       = r_sw;
        n_rst_flag = r_rst_flag;
        n_brk_flag = r_brk_flag;
        n_emu_flag = r_emu_flag;
        res        = '0;
        unique case (i_item.action)
            ACT_WR_MASK: begin
                if (lane_ok) begin
                    n_mask = lane_wr[SRC_W-1:0];
                end
            end
            ACT_WR_PEND: begin
                if (lane_ok) begin
                    n_pend = lane_wr[SRC_W-1:0];
                end
            end
            ACT_RD_MASK: begin
                if (lane_ok) begin
                    res.read_byte = mask_wide[{i_item.byte_offset, 3'b000} +: BYTE_W] & BYTE_ONES;
                end
            end
            ACT_RD_PEND: begin
                if (lane_ok) begin
                    res.read_byte = pend_wide[{i_item.byte_offset, 3'b000} +: BYTE_W] & BYTE_ONES;
                end
            end
            ACT_RAISE: begin
                if ((i_item.source_number != '0) && (i_item.source_number <= src_n)) begin
                    n_pend[i_item.source_number[SRC_IW-1:0]] = 1'b1;
                end
            end
            ACT_NMI: begin
                n_pend[0] = 1'b1;
            end
            ACT_BRK, ACT_RESET: begin
                // break above level 1 escalates to a reset
                if ((i_item.action == ACT_RESET) || (i_item.current_level > 2'd1)) begin
                    n_mask     = '0;
                    n_pend     = '0;
                    n_sw       = '0;
                    n_rst_flag = 1'b1;
                    n_brk_flag = 1'b0;
                    n_emu_flag = 1'b0;
                end else begin
                    n_brk_flag = 1'b1;
                end
            end
            ACT_EMU: begin
                n_emu_flag = 1'b1;
            end
            ACT_SWI: begin
                if ({1'b0, i_item.software_number} < 7'(SOFTWARE_COUNT)) begin
                    n_sw[i_item.software_number[SW_IW-1:0]] = 1'b1;
                end
            end
            ACT_ACCEPT: begin
                priority if (r_rst_flag) begin
                    n_rst_flag     = 1'b0;
                    res.taken      = 1'b1;
                    res.taken_kind = KIND_RESET;
                    res.new_level  = LVL_RESET;
                end else if (sw_found) begin
                    n_sw[sw_idx]     = 1'b0;
                    res.taken        = 1'b1;
                    res.taken_kind   = KIND_SOFTWARE;
                    res.taken_number = SRC_NUM_W'(sw_idx);
                    res.new_level    = LVL_ONE;
                end else if (r_emu_flag) begin
                    n_emu_flag     = 1'b0;
                    res.taken      = 1'b1;
                    res.taken_kind = KIND_EMULATOR;
                    res.new_level  = LVL_EMU;
                end else if (r_brk_flag) begin
                    n_brk_flag     = 1'b0;
                    res.taken      = 1'b1;
                    res.taken_kind = KIND_BREAK;
                    res.new_level  = LVL_TWO;
                end else if (active[0]) begin
                    // nmi at level 3 waits and shadows the maskable sources
                    if (i_item.current_level <= 2'd2) begin
                        n_pend[0]      = 1'b0;
                        res.taken      = 1'b1;
                        res.taken_kind = KIND_NMI;
                        res.new_level  = LVL_TWO;
                    end
                end else if (mk_found && (i_item.current_level <= 2'd1)
                             && i_item.master_enable && !i_item.maskable_blocked) begin
                    n_pend[mk_idx]   = 1'b0;
                    res.taken        = 1'b1;
                    res.taken_kind   = KIND_MASKABLE;
                    res.taken_number = SRC_NUM_W'(mk_idx);
                    res.new_level    = LVL_ONE;
                end else begin
                    res.taken = 1'b0;
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask     <= '0;
            r_pend     <= '0;
            r_sw       <= '0;
            r_rst_flag <= 1'b1;
            r_brk_flag <= 1'b0;
            r_emu_flag <= 1'b0;
        end else if (i_en) begin
            r_mask     <= n_mask;
            r_pend     <= n_pend;
            r_sw       <= n_sw;
            r_rst_flag <= n_rst_flag;
            r_brk_flag <= n_brk_flag;
            r_emu_flag <= n_emu_flag;
        end
    end

    assign o_res = res;

endmodule

`default_nettype wire

// ===== verif/ipc_tb_pkg.sv =====
// expected-result tracker for the interrupt priority controller testbench
package ipc_tb_pkg;
    import ipc_pkg::*;

    class irq_outcome_board;
        logic [REG_BITS-1:0] mask_q;
        logic [REG_BITS-1:0] pend_q;
        logic [REG_BITS-1:0] swi_q;
        bit                  reset_req;
        bit                  break_req;
        bit                  emu_req;
        logic [CFG_W-1:0]    src_cnt;
        bit                  nmi_wr;
        t_result             due_outcomes[$];
        int                  errors;
        int                  beats;
        int                  checked;
        int                  taken_count[6];

        function new();
            src_cnt = SRC_CNT_RST;
            nmi_wr  = 1'b0;
            errors  = 0;
            beats   = 0;
            checked = 0;
            foreach (taken_count[k]) taken_count[k] = 0;
            clear_flags();
        endfunction

        function void clear_flags();
            mask_q    = '0;
            pend_q    = '0;
            swi_q     = '0;
            reset_req = 1'b1;
            break_req = 1'b0;
            emu_req   = 1'b0;
        endfunction

        function void configure(t_cfg_index idx, logic [CFG_W-1:0] val);
            if (idx == CFG_SOURCES_IN_USE) src_cnt = val;
            else nmi_wr = val[0];
        endfunction

        // bits 0..N, bit 0 only when the nmi bit is writable
        function logic [REG_BITS-1:0] writable();
            logic [REG_BITS-1:0] w;
            if (src_cnt == 6'd63) w = '1;
            else w = (64'd1 << (int'(src_cnt) + 1)) - 64'd1;
            if (!nmi_wr) w[0] = 1'b0;
            return w;
        endfunction

        function logic [REG_BITS-1:0] lane_put(logic [REG_BITS-1:0] r, logic [LANE_W-1:0] lane,
                                               logic [BYTE_W-1:0] data);
            r[int'(lane)*8 +: 8] = data;
            return r & writable();
        endfunction

        function t_result arbitrate(t_item it);
            t_result             r;
            logic [REG_BITS-1:0] act;
            int                  n;
            int                  i;
            r = '0;
            n = int'(src_cnt);
            case (it.action)
                ACT_WR_MASK: mask_q = lane_put(mask_q, it.byte_offset, it.write_byte);
                ACT_WR_PEND: pend_q = lane_put(pend_q, it.byte_offset, it.write_byte);
                ACT_RD_MASK: r.read_byte = mask_q[int'(it.byte_offset)*8 +: 8];
                ACT_RD_PEND: r.read_byte = pend_q[int'(it.byte_offset)*8 +: 8];
                ACT_RAISE: begin
                    if (it.source_number >= 1 && int'(it.source_number) <= n)
                        pend_q[it.source_number] = 1'b1;
                end
                ACT_NMI: pend_q[0] = 1'b1;
                ACT_BRK: begin
                    // break above level 1 turns into a reset
                    if (it.current_level > 2'd1) clear_flags();
                    else break_req = 1'b1;
                end
                ACT_EMU: emu_req = 1'b1;
                ACT_SWI: swi_q[it.software_number] = 1'b1;
                ACT_RESET: clear_flags();
                ACT_ACCEPT: begin
                    act = pend_q & mask_q;
                    if (reset_req) begin
                        reset_req    = 1'b0;
                        r.taken      = 1'b1;
                        r.taken_kind = KIND_RESET;
                        r.new_level  = LVL_RESET;
                    end else if (swi_q != '0) begin
                        for (i = 0; i < 64; i++) begin
                            if (swi_q[i]) break;
                        end
                        swi_q[i]       = 1'b0;
                        r.taken        = 1'b1;
                        r.taken_kind   = KIND_SOFTWARE;
                        r.taken_number = SRC_NUM_W'(i);
                        r.new_level    = LVL_ONE;
                    end else if (emu_req) begin
                        emu_req      = 1'b0;
                        r.taken      = 1'b1;
                        r.taken_kind = KIND_EMULATOR;
                        r.new_level  = LVL_EMU;
                    end else if (break_req) begin
                        break_req    = 1'b0;
                        r.taken      = 1'b1;
                        r.taken_kind = KIND_BREAK;
                        r.new_level  = LVL_TWO;
                    end else if (act[0]) begin
                        // nmi held off at level 3, maskable sources not looked at
                        if (it.current_level <= 2'd2) begin
                            pend_q[0]    = 1'b0;
                            r.taken      = 1'b1;
                            r.taken_kind = KIND_NMI;
                            r.new_level  = LVL_TWO;
                        end
                    end else begin
                        for (i = 1; i <= n; i++) begin
                            if (act[i]) begin
                                if (it.current_level <= 2'd1 && it.master_enable &&
                                    !it.maskable_blocked) begin
                                    pend_q[i]      = 1'b0;
                                    r.taken        = 1'b1;
                                    r.taken_kind   = KIND_MASKABLE;
                                    r.taken_number = SRC_NUM_W'(i);
                                    r.new_level    = LVL_ONE;
                                end
                                break;
                            end
                        end
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void log_beat(t_item it);
            t_result r;
            r = arbitrate(it);
            beats++;
            if (r.taken) taken_count[int'(r.taken_kind)]++;
            due_outcomes.push_back(r);
        endfunction

        function void check_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void match_beat(t_result got);
            t_result want;
            if (due_outcomes.size() == 0) begin
                $error("result beat arrived with nothing outstanding");
                errors++;
                return;
            end
            want = due_outcomes.pop_front();
            checked++;
            check_field("read_byte", want.read_byte, got.read_byte);
            check_field("taken", want.taken, got.taken);
            check_field("taken_kind", want.taken_kind, got.taken_kind);
            check_field("taken_number", want.taken_number, got.taken_number);
            check_field("new_level", want.new_level, got.new_level);
        endfunction

        function int outstanding();
            return due_outcomes.size();
        endfunction
    endclass

endpackage

// ===== verif/tb_interrupt_priority_controller_unit.sv =====
// stream-level testbench of the interrupt priority controller with a self-checking tracker
module tb_interrupt_priority_controller_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ipc_pkg::*;
    import ipc_tb_pkg::*;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic             cfg_addr  = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic [31:0]      s_tdata   = '0;
    logic [3:0]       s_tuser   = '0;
    logic             m_tready  = 1'b0;
    wire              s_tready;
    wire              m_tvalid;
    wire  [15:0]      m_tdata;
    wire  [3:0]       m_tuser;

    irq_outcome_board board = new();
    t_result          seen;
    bit               rush = 1'b0;     // no idling on either side while set
    logic [CFG_W-1:0] cur_sources = SRC_CNT_RST;

    interrupt_priority_controller_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

    always #6 clk = ~clk;

    // generous ceiling: ~930 beats at worst-case gaps and stalls need well under 0.5 ms
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // unpack the result beat: tdata read_byte/taken_number/new_level, tuser taken/taken_kind
    always_comb begin
        seen.read_byte    = m_tdata[7:0];
        seen.taken_number = m_tdata[13:8];
        seen.new_level    = m_tdata[15:14];
        seen.taken        = m_tuser[0];
        seen.taken_kind   = t_kind'(m_tuser[3:1]);
    end

    // every accepted result beat is matched against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) board.match_beat(seen);
    end

    // output side: random hold-off before each beat, then ready until one is taken
    initial begin : sink
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever begin
            gap = rush ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // one input beat: optional gap, then hold valid until the handshake
    task automatic push_beat(input t_item it);
        int gap;
        gap = rush ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, it.maskable_blocked, it.current_level, it.master_enable,
                     it.software_number, it.source_number, it.write_byte, it.byte_offset};
        s_tuser  <= it.action;
        do @(posedge clk); while (!s_tready);
        board.log_beat(it);
    endtask

    // drop valid, let every expected result drain, then cover the two-stage latency
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // both registers written back to back while the block is idle
    task automatic load_config(input logic [CFG_W-1:0] srcs, input bit nmi);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_SOURCES_IN_USE;
        cfg_wdata <= srcs;
        @(posedge clk);
        cfg_addr  <= CFG_NMI_BIT_WRITABLE;
        cfg_wdata <= CFG_W'(nmi);
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.configure(CFG_SOURCES_IN_USE, srcs);
        board.configure(CFG_NMI_BIT_WRITABLE, CFG_W'(nmi));
        cur_sources = srcs;
    endtask

    function automatic t_item mk(logic [3:0] act, int off, int byt, int src, int swn,
                                 int lvl, bit me, bit blk);
        t_item it;
        it.action           = act;
        it.byte_offset      = LANE_W'(off);
        it.write_byte       = BYTE_W'(byt);
        it.source_number    = SRC_NUM_W'(src);
        it.software_number  = SRC_NUM_W'(swn);
        it.master_enable    = me;
        it.current_level    = 2'(lvl);
        it.maskable_blocked = blk;
        return it;
    endfunction

    // weighted mix: mostly register setup, raises and accepts that can actually be taken
    function automatic t_item random_beat();
        t_item it;
        int    pick;
        int    top;
        it.byte_offset      = LANE_W'($urandom_range(0, 7));
        it.write_byte       = BYTE_W'($urandom_range(0, 255));
        it.source_number    = SRC_NUM_W'($urandom_range(0, 63));
        it.software_number  = SRC_NUM_W'($urandom_range(0, 63));
        it.master_enable    = ($urandom_range(0, 3) != 0);
        it.current_level    = 2'($urandom_range(0, 3));
        it.maskable_blocked = ($urandom_range(0, 3) == 0);
        top  = (cur_sources == 0) ? 1 : int'(cur_sources);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            it.action = ACT_WR_MASK;
            if ($urandom_range(0, 1) != 0) it.write_byte = BYTE_ONES;
        end else if (pick < 18) begin
            it.action = ACT_WR_PEND;
        end else if (pick < 24) begin
            it.action = ACT_RD_MASK;
        end else if (pick < 30) begin
            it.action = ACT_RD_PEND;
        end else if (pick < 48) begin
            it.action = ACT_RAISE;
            if ($urandom_range(0, 6) != 0) it.source_number = SRC_NUM_W'($urandom_range(1, top));
        end else if (pick < 52) begin
            it.action = ACT_NMI;
        end else if (pick < 57) begin
            it.action = ACT_BRK;
            // keep most breaks from wiping the state
            if ($urandom_range(0, 4) != 0) it.current_level = 2'($urandom_range(0, 1));
        end else if (pick < 61) begin
            it.action = ACT_EMU;
        end else if (pick < 67) begin
            it.action = ACT_SWI;
        end else if (pick < 69) begin
            it.action = ACT_RESET;
        end else if (pick < 97) begin
            it.action = ACT_ACCEPT;
            if ($urandom_range(0, 2) != 0) it.current_level = 2'($urandom_range(0, 1));
        end else begin
            it.action = 4'($urandom_range(11, 15));   // undefined codes
        end
        return it;
    endfunction

    initial begin : stimulus
        int src_tab[6];
        int nmi_tab[6];
        int ph;
        int k;
        src_tab = '{63, 1, 0, 21, 0, 0};
        nmi_tab = '{1, 0, 1, 0, 0, 0};
        src_tab[4] = $urandom_range(0, 63);
        src_tab[5] = $urandom_range(0, 63);
        nmi_tab[4] = $urandom_range(0, 1);
        nmi_tab[5] = $urandom_range(0, 1);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with 21 sources and the nmi bit writable
        load_config(SRC_CNT_RST, 1'b1);
        push_beat(mk(ACT_ACCEPT,  0, 0,    0,  0, 0, 1, 0));  // reset interrupt after power-up
        push_beat(mk(ACT_ACCEPT,  0, 0,    0,  0, 0, 1, 0));  // nothing pending
        push_beat(mk(ACT_WR_MASK, 0, 8'hFF, 0, 0, 0, 1, 0));
        push_beat(mk(ACT_WR_MASK, 2, 8'hFF, 0, 0, 0, 1, 0));  // cut above source 21
        push_beat(mk(ACT_RD_MASK, 2, 0,    0,  0, 0, 1, 0));
        push_beat(mk(ACT_RAISE,   0, 0,    0,  0, 0, 1, 0));  // source 0 ignored
        push_beat(mk(ACT_RAISE,   0, 0,    1,  0, 0, 1, 0));
        push_beat(mk(ACT_WR_PEND, 7, 8'hFF, 0, 0, 0, 1, 0));  // top lane, all above the sources
        push_beat(mk(ACT_RD_PEND, 0, 0,    0,  0, 0, 1, 0));
        push_beat(mk(ACT_NMI,     0, 0,    0,  0, 0, 1, 0));
        push_beat(mk(ACT_ACCEPT,  0, 0,    0,  0, 3, 1, 0));  // nmi held at level 3
        push_beat(mk(ACT_ACCEPT,  0, 0,    0,  0, 2, 1, 0));
        push_beat(mk(ACT_SWI,     0, 0,    0, 63, 0, 1, 0));
        push_beat(mk(ACT_SWI,     0, 0,    0,  0, 0, 1, 0));
        push_beat(mk(ACT_EMU,     0, 0,    0,  0, 0, 1, 0));
        push_beat(mk(ACT_BRK,     0, 0,    0,  0, 1, 1, 0));
        push_beat(mk(ACT_ACCEPT,  0, 0,    0,  0, 0, 1, 0));  // software 0 first
        push_beat(mk(ACT_ACCEPT,  0, 0,    0,  0, 0, 1, 0));
        push_beat(mk(ACT_ACCEPT,  0, 0,    0,  0, 0, 1, 0));  // emulator
        push_beat(mk(ACT_ACCEPT,  0, 0,    0,  0, 0, 1, 0));  // break
        push_beat(mk(ACT_ACCEPT,  0, 0,    0,  0, 0, 0, 0));  // master enable off
        push_beat(mk(ACT_ACCEPT,  0, 0,    0,  0, 0, 1, 1));  // blocked
        push_beat(mk(ACT_ACCEPT,  0, 0,    0,  0, 1, 1, 0));  // source 1 taken
        push_beat(mk(ACT_BRK,     0, 0,    0,  0, 3, 1, 0));  // break becomes reset
        push_beat(mk(4'd15,       0, 0,    0,  0, 0, 1, 0));  // undefined code
        push_beat(mk(ACT_RESET,   0, 0,    0,  0, 0, 1, 0));
        settle();

        // random phases, each under its own configuration
        for (ph = 0; ph < 6; ph++) begin
            load_config(CFG_W'(src_tab[ph]), nmi_tab[ph][0]);
            for (k = 0; k < 150; k++) begin
                if (k % 30 == 0) rush = ($urandom_range(0, 3) == 0);
                push_beat(random_beat());
            end
            settle();
        end

        $display("covered %0d beats over 7 settings (1 directed, 6 random), %0d results checked",
                 board.beats, board.checked);
        $display("taken: reset %0d, software %0d, emulator %0d, break %0d, nmi %0d, maskable %0d",
                 board.taken_count[0], board.taken_count[1], board.taken_count[2],
                 board.taken_count[3], board.taken_count[4], board.taken_count[5]);
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
